// ===== src/utf8_to_winansi_transcoder_top_macros.svh =====
// Assertion macros shared by the transcoder modules.
`ifndef UTF8_TO_WINANSI_TRANSCODER_TOP_MACROS_SVH
`define UTF8_TO_WINANSI_TRANSCODER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define U2W_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define U2W_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/u2w_pkg.sv =====
`default_nettype none

package u2w_pkg;

   localparam logic [7:0] QuestionMark = 8'h3F;
   localparam logic [2:0] LeadInvalid  = 3'd4;

   // Result queue: room for one waiting result plus the three that one item can cause.
   localparam int MaxResults = 3;
   localparam int QueueDepth = MaxResults + 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } u2w_result_type;

   typedef struct packed {
      logic [1:0]           count;
      u2w_result_type [2:0] item;
   } u2w_decode_type;

   // Number of continuation bytes announced by a lead byte, or LeadInvalid.
   function automatic logic [2:0] lead_extra(input logic [7:0] b);
      logic [2:0] extra;
      if (b inside {[8'h00:8'h7F]}) extra = 3'd0;
      else if (b inside {[8'hC0:8'hDF]}) extra = 3'd1;
      else if (b inside {[8'hE0:8'hEF]}) extra = 3'd2;
      else if (b inside {[8'hF0:8'hF7]}) extra = 3'd3;
      else extra = LeadInvalid;
      return extra;
   endfunction

   // A byte decoded alone: plain ASCII survives, anything else is malformed.
   function automatic logic [7:0] single_byte(input logic [7:0] b);
      return b[7] ? QuestionMark : b;
   endfunction

   // Code point to Windows-1252 byte.
   function automatic logic [7:0] map_code(input logic [20:0] cp);
      logic [7:0] r;
      if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
         r = cp[7:0];
      end else begin
         case (cp)
            21'h020AC: r = 8'h80;
            21'h0201A: r = 8'h82;
            21'h00192: r = 8'h83;
            21'h0201E: r = 8'h84;
            21'h02026: r = 8'h85;
            21'h02020: r = 8'h86;
            21'h02021: r = 8'h87;
            21'h002C6: r = 8'h88;
            21'h02030: r = 8'h89;
            21'h00160: r = 8'h8A;
            21'h02039: r = 8'h8B;
            21'h00152: r = 8'h8C;
            21'h0017D: r = 8'h8E;
            21'h02018: r = 8'h91;
            21'h02019: r = 8'h92;
            21'h0201C: r = 8'h93;
            21'h0201D: r = 8'h94;
            21'h02022: r = 8'h95;
            21'h02013: r = 8'h96;
            21'h02014: r = 8'h97;
            21'h002DC: r = 8'h98;
            21'h02122: r = 8'h99;
            21'h00161: r = 8'h9A;
            21'h0203A: r = 8'h9B;
            21'h00153: r = 8'h9C;
            21'h0017E: r = 8'h9E;
            21'h00178: r = 8'h9F;
            default:   r = QuestionMark;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/u2w_if.sv =====
`default_nettype none

interface u2w_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u2w_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

`default_nettype wire

// ===== src/utf8_to_winansi_transcoder_top.sv =====
// UTF-8 to Windows-1252 transcoder. Raw UTF-8 bytes enter on the req channel one item per
// byte, with end_of_text set on the last byte of each string; Windows-1252 bytes leave on
// the rsp channel, and run_end marks the last result that a given input byte caused. A lead
// byte announces zero to three continuation bytes, whose low six bits are gathered without
// any check. Completed code points below 0x80 or from 0xA0 to 0xFF pass unchanged, the 27
// characters that Windows-1252 keeps at 0x80-0x9F map to their codes, and everything else,
// including invalid lead bytes, becomes '?'. A string that ends inside a sequence yields '?'
// for the lead, followed by a fresh decode of the continuation bytes taken so far. An input
// byte causes zero to three results. The block accepts one item per cycle as long as each
// item causes at most one result and the result side keeps up; an item that causes two or
// three results can hold up later items, since the result queue hands out one result per
// cycle while the result side is ready. An accepted item passes through the input register
// and then the result queue before its first result is offered.
`default_nettype none
`include "utf8_to_winansi_transcoder_top_macros.svh"

module utf8_to_winansi_transcoder_top (
   input  logic clock,
   input  logic reset,
   u2w_req_if.sink   req_ch,
   u2w_rsp_if.source rsp_ch
);
   import u2w_pkg::*;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result queue, head at entry zero.
   u2w_result_type        q_ff [QueueDepth];
   u2w_result_type        q_in [QueueDepth];
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  pop;
   logic                  advance;
   logic [CountWidth-1:0] base;
   u2w_decode_type        dec;

   // The held item moves into the queue only when all its results are sure to fit.
   assign pop     = (count_ff != '0) && rsp_ch.ready;
   assign base    = count_ff - CountWidth'(pop);
   assign advance = in_valid_ff && (base <= CountWidth'(QueueDepth - MaxResults));

   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.in_byte;
         in_last_ff <= req_ch.end_of_text;
      end
   end

   // Decoder state advances only when the item actually leaves the input register.
   u2w_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .end_of_text (in_last_ff),
      .dec         (dec)
   );

   // Shift out the head when it is taken, then append the new results behind what remains.
   always_comb begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_in[QueueDepth - 1] = q_ff[QueueDepth - 1];
      for (int i = 0; i < QueueDepth; i++) begin
         for (int k = 0; k < MaxResults; k++) begin
            if (advance && (2'(k) < dec.count) &&
                (CountWidth'(i) == base + CountWidth'(k))) begin
               q_in[i] = dec.item[k];
            end
         end
      end
      count_in = base + (advance ? CountWidth'(dec.count) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      q_ff <= q_in;
   end

   assign rsp_ch.valid    = (count_ff != '0);
   assign rsp_ch.out_byte = q_ff[0].out_byte;
   assign rsp_ch.run_end  = q_ff[0].run_end;

   `U2W_CHECK(a_queue_bound, clock, reset, count_ff <= CountWidth'(QueueDepth), "result queue overflow")
   `U2W_CHECK_NEXT(a_results_queued, clock, reset, advance, (count_ff != '0) || ($past(dec.count) == 2'd0), "decoded results not queued")
   `U2W_CHECK_NEXT(a_stall_keeps, clock, reset, rsp_ch.valid && !rsp_ch.ready, count_ff >= $past(count_ff), "results lost while output stalled")

endmodule

`default_nettype wire

// ===== src/u2w_decoder.sv =====
`default_nettype none
`include "utf8_to_winansi_transcoder_top_macros.svh"

module u2w_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              in_byte,
   input  logic                    end_of_text,
   output u2w_pkg::u2w_decode_type dec
);
   import u2w_pkg::*;

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  needed_ff, needed_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  held0_ff, held0_in;

   always_comb begin
      logic [2:0]  extra;
      logic [1:0]  need_dec;
      logic [20:0] acc_shift;

      extra     = lead_extra(in_byte);
      need_dec  = needed_ff - 2'd1;
      acc_shift = {acc_ff[14:0], in_byte[5:0]};

      dec         = '0;
      acc_in      = acc_ff;
      needed_in   = needed_ff;
      held_cnt_in = held_cnt_ff;
      held0_in    = held0_ff;

      if (step) begin
         if (needed_ff == 2'd0) begin
            if (extra == 3'd0) begin
               dec.count   = 2'd1;
               dec.item[0] = '{out_byte: map_code({13'd0, in_byte}), run_end: 1'b1};
            end else if (extra == LeadInvalid || end_of_text) begin
               dec.count   = 2'd1;
               dec.item[0] = '{out_byte: QuestionMark, run_end: 1'b1};
            end else begin
               acc_in      = {13'd0, in_byte & (8'h3F >> extra)};
               needed_in   = extra[1:0];
               held_cnt_in = 2'd0;
            end
         end else begin
            acc_in    = acc_shift;
            needed_in = need_dec;
            if (held_cnt_ff == 2'd0) begin
               held0_in = in_byte;
            end
            held_cnt_in = held_cnt_ff + 2'd1;
            if (need_dec == 2'd0) begin
               dec.count   = 2'd1;
               dec.item[0] = '{out_byte: map_code(acc_shift), run_end: 1'b1};
               held_cnt_in = 2'd0;
            end else if (end_of_text) begin
               // The lead is reported as malformed, then the bytes after it are
               // decoded again as a short string of their own.
               dec.item[0] = '{out_byte: QuestionMark, run_end: 1'b0};
               if (held_cnt_ff == 2'd0) begin
                  dec.count   = 2'd2;
                  dec.item[1] = '{out_byte: single_byte(in_byte), run_end: 1'b1};
               end else if (held0_ff[7:5] == 3'b110) begin
                  dec.count   = 2'd2;
                  dec.item[1] = '{out_byte: map_code({10'd0, held0_ff[4:0], in_byte[5:0]}),
                                  run_end: 1'b1};
               end else begin
                  dec.count   = 2'd3;
                  dec.item[1] = '{out_byte: single_byte(held0_ff), run_end: 1'b0};
                  dec.item[2] = '{out_byte: single_byte(in_byte), run_end: 1'b1};
               end
            end
         end
         if (end_of_text) begin
            needed_in   = 2'd0;
            held_cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff   <= 2'd0;
         held_cnt_ff <= 2'd0;
      end else begin
         needed_ff   <= needed_in;
         held_cnt_ff <= held_cnt_in;
      end
      acc_ff   <= acc_in;
      held0_ff <= held0_in;
   end

   `U2W_CHECK(a_held_within_seq, clock, reset, (held_cnt_ff != 2'd0) |-> (needed_ff != 2'd0), "bytes held outside an open sequence")
   `U2W_CHECK(a_held_bound, clock, reset, held_cnt_ff != 2'd3, "more continuation bytes held than a sequence can leave open")
   `U2W_CHECK_NEXT(a_end_closes, clock, reset, step && end_of_text, needed_ff == 2'd0 && held_cnt_ff == 2'd0, "end of text left a sequence open")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

   // The Unicode characters that Windows-1252 places at 0x80-0x9F, by position.
   // Zero marks the five positions that Windows-1252 leaves unassigned.
   localparam logic [15:0] C1_UNICODE [32] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   // Enough input items for a thorough run, counting the directed strings.
   localparam int TargetBytes = 230;

   // Scoreboard: a private copy of the decoder state and the Windows-1252 bytes still
   // owed by the block, oldest first.
   class winansi_tracker;
      logic [20:0]            code_acc;
      logic [1:0]             still_needed;
      logic [1:0]             held_count;
      logic [7:0]             held_bytes [3];
      logic [7:0]             step_out [$];
      u2w_pkg::u2w_result_type expected_winansi [$];
      int unsigned            failures;

      function new();
         code_acc     = '0;
         still_needed = '0;
         held_count   = '0;
         failures     = 0;
      endfunction

      // Adds one result byte owed for the input item being noted.
      function void owe_byte(logic [7:0] v);
         step_out = {step_out, v};
      endfunction

      // Continuation bytes announced by a lead byte; LeadInvalid for a bad lead.
      function logic [2:0] follow_count(logic [7:0] b);
         if (!b[7]) return 3'd0;
         if (b[7:5] == 3'b110) return 3'd1;
         if (b[7:4] == 4'b1110) return 3'd2;
         if (b[7:3] == 5'b11110) return 3'd3;
         return u2w_pkg::LeadInvalid;
      endfunction

      function logic [7:0] to_winansi(logic [20:0] cp);
         logic [7:0] r;
         if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) return cp[7:0];
         r = u2w_pkg::QuestionMark;
         for (int k = 0; k < 32; k++) begin
            if (C1_UNICODE[k] != 16'h0 && {5'd0, C1_UNICODE[k]} == cp) r = 8'h80 + 8'(k);
         end
         return r;
      endfunction

      // Replays the first n held bytes as a complete string of their own.
      function void replay_held(int n);
         int          i;
         logic [2:0]  extra;
         logic [20:0] cp;
         i = 0;
         while (i < n) begin
            extra = follow_count(held_bytes[i]);
            if (extra == u2w_pkg::LeadInvalid || (extra != 0 && i + int'(extra) >= n)) begin
               owe_byte(u2w_pkg::QuestionMark);
               i++;
            end else begin
               cp = {13'd0, held_bytes[i]};
               if (extra != 0) begin
                  cp = {13'd0, held_bytes[i] & (8'h3F >> extra)};
                  for (int k = 1; k <= int'(extra); k++)
                     cp = (cp << 6) | {15'd0, held_bytes[i + k][5:0]};
               end
               i += int'(extra) + 1;
               owe_byte(to_winansi(cp));
            end
         end
      endfunction

      // Called for every input item the block takes.
      function void accept_utf8_byte(logic [7:0] b, logic close);
         logic [2:0]             extra;
         u2w_pkg::u2w_result_type r;
         step_out.delete();
         if (still_needed == 2'd0) begin
            extra = follow_count(b);
            if (extra == 3'd0) begin
               owe_byte(to_winansi({13'd0, b}));
            end else if (extra == u2w_pkg::LeadInvalid || close) begin
               owe_byte(u2w_pkg::QuestionMark);
            end else begin
               code_acc     = {13'd0, b & (8'h3F >> extra)};
               still_needed = extra[1:0];
               held_count   = 2'd0;
            end
         end else begin
            code_acc = (code_acc << 6) | {15'd0, b[5:0]};
            if (held_count < 2'd3) begin
               held_bytes[held_count] = b;
               held_count++;
            end
            still_needed--;
            if (still_needed == 2'd0) begin
               owe_byte(to_winansi(code_acc));
               code_acc   = '0;
               held_count = 2'd0;
            end else if (close) begin
               // The string ended inside a sequence: '?' for the lead, then the
               // bytes taken after it are decoded again from scratch.
               owe_byte(u2w_pkg::QuestionMark);
               replay_held(held_count < 2'd2 ? int'(held_count) : 2);
            end
         end
         if (close) begin
            code_acc     = '0;
            still_needed = 2'd0;
            held_count   = 2'd0;
         end
         foreach (step_out[k]) begin
            r.out_byte = step_out[k];
            r.run_end  = (k == step_out.size() - 1);
            expected_winansi = {expected_winansi, r};
         end
      endfunction

      // Called for every result item the block hands out.
      function void check_winansi_byte(logic [7:0] out_byte, logic run_end);
         u2w_pkg::u2w_result_type want;
         if (expected_winansi.size() == 0) begin
            $error("unexpected result: out_byte %02h run_end %0b", out_byte, run_end);
            failures++;
            return;
         end
         want = expected_winansi.pop_front();
         if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
            failures++;
         end
         if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   u2w_req_if req_ch ();
   u2w_rsp_if rsp_ch ();

   utf8_to_winansi_transcoder_top uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   winansi_tracker winansi_check = new();

   // Bytes of the string about to be sent, and the count of input items taken so far.
   logic [7:0] text_bytes [$];
   int         bytes_sent;

   // While set, neither side idles, so the block runs at full rate.
   bit no_idling;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idling || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 30);
   endfunction

   // Adds one byte at the end of the string being built.
   function automatic void add_text_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   // Both channels are watched at the rising edge. The testbench drives its side with
   // nonblocking assignments, so every value seen here is the one from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            winansi_check.accept_utf8_byte(req_ch.in_byte, req_ch.end_of_text);
         if (rsp_ch.valid && rsp_ch.ready)
            winansi_check.check_winansi_byte(rsp_ch.out_byte, rsp_ch.run_end);
      end
   end

   // The result side accepts in bursts of random length broken by random stalls.
   initial begin
      int run_len;
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         run_len = $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Offers one input item and waits until the block takes it. Valid stays high so that
   // a following item can go out on the very next cycle.
   task automatic send_byte(input logic [7:0] b, input logic close);
      req_ch.valid       <= 1'b1;
      req_ch.in_byte     <= b;
      req_ch.end_of_text <= close;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   // Sends the bytes in text_bytes, with a random gap after each. When close is set
   // the last byte carries end_of_text.
   task automatic send_text(input bit close);
      int gap;
      foreach (text_bytes[i]) begin
         send_byte(text_bytes[i], close && (i == text_bytes.size() - 1));
         gap = pick_gap();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      text_bytes.delete();
   endtask

   // Holds the sender off until every owed result has come out. The first edge gives
   // the scoreboard time to note the item taken at the current edge.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (winansi_check.expected_winansi.size() != 0) @(posedge clock);
   endtask

   // Appends the UTF-8 encoding of one code point.
   task automatic append_code(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_text_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         add_text_byte({3'b110, cp[10:6]});
         add_text_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_text_byte({4'b1110, cp[15:12]});
         add_text_byte({2'b10, cp[11:6]});
         add_text_byte({2'b10, cp[5:0]});
      end else begin
         add_text_byte({5'b11110, cp[20:18]});
         add_text_byte({2'b10, cp[17:12]});
         add_text_byte({2'b10, cp[11:6]});
         add_text_byte({2'b10, cp[5:0]});
      end
   endtask

   // Builds one random string. Most strings are well-formed UTF-8 with characters drawn
   // so that plain ASCII, Latin-1, the C1 substitutes, unmapped code points of every
   // length and stray bytes all show up; some get a byte replaced by noise, and some get
   // cut short so that the end of text may fall inside a sequence.
   task automatic build_random_text();
      int          chars;
      int          r;
      int          idx;
      int          cut;
      logic [20:0] cp;
      chars = $urandom_range(1, 6);
      repeat (chars) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            append_code(21'($urandom_range(0, 16'h7F)));
         end else if (r < 50) begin
            append_code(21'($urandom_range(16'hA0, 16'hFF)));
         end else if (r < 70) begin
            do idx = $urandom_range(0, 31); while (C1_UNICODE[idx] == 16'h0);
            append_code({5'd0, C1_UNICODE[idx]});
         end else if (r < 80) begin
            append_code(21'($urandom_range(16'h80, 16'h7FF)));
         end else if (r < 90) begin
            append_code(21'($urandom_range(16'h800, 16'hFFFF)));
         end else if (r < 95) begin
            cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            append_code(cp);
         end else begin
            add_text_byte(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 12)
         text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15 && text_bytes.size() > 1) begin
         cut = $urandom_range(1, text_bytes.size() - 1);
         repeat (cut) void'(text_bytes.pop_back());
      end
   endtask

   initial begin
      int strings_done;
      bytes_sent   = 0;
      strings_done = 0;
      no_idling    = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.in_byte     <= 8'h00;
      req_ch.end_of_text <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings. The lowest and highest ASCII bytes, with and without the end
      // of text, and two invalid lead bytes at the edges of the range above it.
      text_bytes = '{8'h00}; send_text(1'b0);
      text_bytes = '{8'h7F}; send_text(1'b1);
      text_bytes = '{8'h80}; send_text(1'b0);
      text_bytes = '{8'hFF}; send_text(1'b1);
      // A Latin-1 letter ending the text, then the euro sign, whose first two bytes
      // cause no result at all.
      text_bytes = '{8'hC3, 8'hA9}; send_text(1'b1);
      text_bytes = '{8'hE2, 8'h82, 8'hAC}; send_text(1'b0);
      // A code point in the C1 range with no Windows-1252 character gives '?'.
      text_bytes = '{8'hC2, 8'h81}; send_text(1'b1);
      // An overlong encoding of zero and a surrogate are taken as they stand.
      text_bytes = '{8'hC0, 8'h80}; send_text(1'b0);
      text_bytes = '{8'hED, 8'hA0, 8'h80}; send_text(1'b0);
      // A multi-byte lead that is the last byte of the text.
      text_bytes = '{8'hE2}; send_text(1'b1);
      // Sequences cut off by the end of text: the bytes after the lead are decoded
      // again, giving a Latin-1 letter, two ASCII letters, and a broken lead plus a
      // stray continuation byte, that is up to three results from a single item.
      text_bytes = '{8'hF0, 8'hC3, 8'hA9}; send_text(1'b1);
      text_bytes = '{8'hF0, 8'h41, 8'h42}; send_text(1'b1);
      text_bytes = '{8'hF0, 8'hE2, 8'h82}; send_text(1'b1);

      // Let everything settle before the random part starts.
      wait_for_drain();

      // Random strings. One stretch runs with no idling on either side, and now and
      // then the sender holds off until the block has caught up.
      while (bytes_sent < TargetBytes) begin
         no_idling = (strings_done >= 20 && strings_done < 32);
         build_random_text();
         send_text(1'b1);
         strings_done++;
         if ($urandom_range(0, 99) < 5) wait_for_drain();
      end

      // Wait for the last results, then keep watching for any result that the block should
      // not produce.
      no_idling = 1'b0;
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (winansi_check.failures == 0 && winansi_check.expected_winansi.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run with every gap at its longest.
   initial begin
      #4000000;
      $error("timeout with %0d results outstanding", winansi_check.expected_winansi.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
